[design/srlb_pkg.sv]
// Shared constants, types and helpers for the sorted-range lower-bound search core.
package srlb_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = 10;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [POS_W-1:0]        t_pos;
    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_val              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic t_pos f_mid(input t_pos lo, input t_pos hi);
        t_pos span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

endpackage

[design/srlb_if.sv]
// Request and response channel interfaces for the lower-bound search core.
interface srlb_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [srlb_pkg::IDX_W-1:0]    element_index;
    logic signed [srlb_pkg::VAL_W-1:0] element_value;
    logic [srlb_pkg::POS_W-1:0]    range_start;
    logic [srlb_pkg::POS_W-1:0]    range_end;
    logic signed [srlb_pkg::VAL_W-1:0] target;

    modport source (
        output valid, action, element_index, element_value, range_start, range_end, target,
        input  ready
    );
    modport sink (
        input  valid, action, element_index, element_value, range_start, range_end, target,
        output ready
    );
endinterface

interface srlb_out_if;
    logic                       valid;
    logic                       ready;
    logic [srlb_pkg::POS_W-1:0] position;
    logic                       not_found;

    modport source (output valid, position, not_found, input ready);
    modport sink (input valid, position, not_found, output ready);
endinterface

[design/srlb_mem.sv]
// Value store: one write port, one read port with registered read data.
module srlb_mem (
    input  logic               i_clk,
    input  srlb_pkg::t_mem_req i_req,
    output srlb_pkg::t_val     o_rdata
);

    srlb_pkg::t_val r_mem [srlb_pkg::DEPTH];
    srlb_pkg::t_val r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/srlb_seq.sv]
// Search sequencer: bound update unit, query control and result register.
module srlb_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    srlb_in_if.sink            i_req,
    srlb_out_if.source         o_rsp,
    output srlb_pkg::t_mem_req o_mem_req,
    input  srlb_pkg::t_val     i_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SRCH = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]     r_state, n_state;
    srlb_pkg::t_pos r_lo, n_lo;
    srlb_pkg::t_pos r_hi, n_hi;
    srlb_pkg::t_pos r_mid, n_mid;
    srlb_pkg::t_pos r_end, n_end;
    srlb_pkg::t_val r_tgt, n_tgt;
    logic           r_ov;
    srlb_pkg::t_pos r_pos;
    logic           r_nf;

    srlb_pkg::t_pos sat_lo, sat_hi, st_lo, st_hi;
    logic           is_below, out_free;

    // range clamp
    always_comb begin
        sat_hi = (i_req.range_end > srlb_pkg::POS_W'(srlb_pkg::DEPTH)) ?
                 srlb_pkg::POS_W'(srlb_pkg::DEPTH) : i_req.range_end;
        sat_lo = (i_req.range_start > sat_hi) ? sat_hi : i_req.range_start;
    end

    // shared step: compare the probed value and narrow the bounds
    assign is_below = i_rdata < r_tgt;
    assign st_lo    = is_below ? r_mid + srlb_pkg::POS_W'(1) : r_lo;
    assign st_hi    = is_below ? r_hi : r_mid;
    assign out_free = !r_ov || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_end   = r_end;
        n_tgt   = r_tgt;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = i_req.element_index[srlb_pkg::ADDR_W-1:0];
        o_mem_req.wdata = i_req.element_value;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.action == srlb_pkg::ACT_WRITE) begin
                        o_mem_req.we = ({1'b0, i_req.element_index} <
                                        srlb_pkg::POS_W'(srlb_pkg::DEPTH));
                    end else begin
                        n_lo  = sat_lo;
                        n_hi  = sat_hi;
                        n_end = sat_hi;
                        n_tgt = i_req.target;
                        if (sat_lo < sat_hi) begin
                            n_mid   = srlb_pkg::f_mid(sat_lo, sat_hi);
                            n_state = ST_SRCH;
                        end else begin
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_SRCH: begin
                n_lo = st_lo;
                n_hi = st_hi;
                if (st_lo < st_hi) begin
                    n_mid = srlb_pkg::f_mid(st_lo, st_hi);
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        o_mem_req.raddr = n_mid[srlb_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_end <= n_end;
        r_tgt <= n_tgt;
        if (r_state == ST_FIN && out_free) begin
            r_pos <= r_lo;
            r_nf  <= !(r_lo < r_end);
        end
    end

    assign i_req.ready     = (r_state == ST_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.position  = r_pos;
    assign o_rsp.not_found = r_nf;

endmodule

[design/sorted_range_lower_bound_search_core.sv]
// Top level of the sorted-range lower-bound search core.
// Usage:
//   i_req carries one word per item. action WRITE stores element_value at
//   element_index, with no response. action QUERY searches [range_start,
//   range_end) for the first entry not below target. o_rsp returns one
//   word per query: position, and not_found when no entry in the range
//   reaches target (position is then the clamped range end).
// Timing:
//   A query runs one bound-narrowing step per cycle on the shared compare
//   unit, fed by the single registered memory read port, and takes up to
//   ceil(log2(n+1)) steps for a range of n entries before the result loads.
//   i_req.ready is low while a query is in flight and returns in the same
//   cycle as the result loads into o_rsp, so a new query is taken only
//   after the last one has loaded its result; writes are taken back to
//   back while idle.
// Reset: the sequencer returns to idle and o_rsp.valid drops; stored values
//   are not cleared and must be written before they are searched.
// Stall: the result register holds the word while o_rsp.ready is low; a
//   new item is taken meanwhile, and a finished query waits for the slot.
module sorted_range_lower_bound_search_core (
    input logic        i_clk,
    input logic        i_rst_n,
    srlb_in_if.sink    i_req,
    srlb_out_if.source o_rsp
);

    srlb_pkg::t_mem_req mem_req;
    srlb_pkg::t_val     mem_rdata;

    srlb_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata)
    );

    srlb_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

[design/srlb_chk.sv]
// Port-level checker for the lower-bound search core, bound to the top level.
module srlb_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_in_action,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [srlb_pkg::POS_W-1:0] i_out_position,
    input logic                   i_out_not_found
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_action == srlb_pkg::ACT_QUERY |=> !i_in_ready)
        else $error("input ready after query accept");

    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_action == srlb_pkg::ACT_WRITE |=> i_in_ready)
        else $error("write stalled the input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_position) && $stable(i_out_not_found))
        else $error("response word changed under stall");

endmodule

bind sorted_range_lower_bound_search_core srlb_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_in_action     (i_req.action),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_position  (o_rsp.position),
    .i_out_not_found (o_rsp.not_found)
);

[tb/srlb_lower_bound_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the lower-bound search core: mirrors the array, predicts and compares answers.
module srlb_lower_bound_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    srlb_in_if   i_req,
    srlb_out_if  i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_not_found
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        srlb_pkg::t_pos position;
        logic           not_found;
    } t_lb_answer;

    srlb_pkg::t_val array_copy [srlb_pkg::DEPTH];
    t_lb_answer     answers_due [$];
    int             error_count     = 0;
    int             pending_count   = 0;
    int             checked_count   = 0;
    int             not_found_count = 0;

    assign o_errors    = error_count;
    assign o_pending   = pending_count;
    assign o_checked   = checked_count;
    assign o_not_found = not_found_count;

    function automatic t_lb_answer lower_bound(input srlb_pkg::t_pos first,
                                               input srlb_pkg::t_pos stop,
                                               input srlb_pkg::t_val goal);
        int         lo;
        int         hi;
        int         mid;
        int         limit;
        t_lb_answer ans;
        hi = (stop > srlb_pkg::DEPTH) ? srlb_pkg::DEPTH : int'(stop);
        lo = (first > hi) ? hi : int'(first);
        limit = hi;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (array_copy[mid] < goal) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        ans.position  = srlb_pkg::t_pos'(lo);
        ans.not_found = (lo >= limit);
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_lb_answer want;
        if (!i_rst_n) begin
            answers_due.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (answers_due.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected answer word: position=%0d not_found=%0b",
                                 i_rsp.position, i_rsp.not_found);
                end else begin
                    want = answers_due.pop_front();
                    checked_count++;
                    if (want.not_found)
                        not_found_count++;
                    if (i_rsp.position !== want.position ||
                        i_rsp.not_found !== want.not_found) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"answer mismatch: expected position=%0d not_found=%0b,",
                                      " got position=%0d not_found=%0b"},
                                     want.position, want.not_found,
                                     i_rsp.position, i_rsp.not_found);
                    end
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                if (i_req.action == srlb_pkg::ACT_WRITE) begin
                    array_copy[i_req.element_index] = i_req.element_value;
                end else begin
                    answers_due.push_back(lower_bound(i_req.range_start, i_req.range_end,
                                                      i_req.target));
                end
            end
        end
        pending_count = answers_due.size();
    end

endmodule

[tb/sorted_range_lower_bound_search_core_test.sv]
`timescale 1ns / 100ps
// Testbench top for the lower-bound search core: clock, reset, stimulus and verdict.
module sorted_range_lower_bound_search_core_test;

    localparam int   ITEM_TOTAL    = 1100;
    localparam int   LONG_HOLD     = 400;
    localparam int   HOLD_AFTER    = 450;
    localparam int   DRAIN_EVERY   = 300;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   POS_TOP       = 2047;
    localparam srlb_pkg::t_val VAL_MIN = {1'b1, {(srlb_pkg::VAL_W-1){1'b0}}};
    localparam srlb_pkg::t_val VAL_MAX = {1'b0, {(srlb_pkg::VAL_W-1){1'b1}}};

    logic clk;
    logic rst_n;

    srlb_in_if  req_ch ();
    srlb_out_if rsp_ch ();

    int             errors;
    int             pending;
    int             checked;
    int             not_found_seen;
    int             cycle_count  = 0;
    int             writes_sent  = 0;
    int             queries_sent = 0;
    logic           hold_request = 1'b0;
    logic           hold_served  = 1'b0;
    logic           loaded [srlb_pkg::DEPTH];
    srlb_pkg::t_val shadow [srlb_pkg::DEPTH];
    int             cursor;
    longint         cursor_val;

    sorted_range_lower_bound_search_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    srlb_lower_bound_checker scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_not_found (not_found_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding", cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // answer side: stretches of differing stall density, plus one long hold-off
    initial begin
        int mode;
        int stretch;
        rsp_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(4, 48);
            repeat (stretch) begin
                @(negedge clk);
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            if (hold_request && !hold_served) begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_served = 1'b1;
            end
        end
    end

    task automatic drive_word(input logic act, input logic [srlb_pkg::IDX_W-1:0] idx,
                              input srlb_pkg::t_val val, input srlb_pkg::t_pos first,
                              input srlb_pkg::t_pos stop, input srlb_pkg::t_val goal);
        req_ch.action        <= act;
        req_ch.element_index <= idx;
        req_ch.element_value <= val;
        req_ch.range_start   <= first;
        req_ch.range_end     <= stop;
        req_ch.target        <= goal;
        req_ch.valid         <= 1'b1;
        do begin
            @(posedge clk);
        end while (req_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic send_write(input int idx, input srlb_pkg::t_val val);
        loaded[idx] = 1'b1;
        shadow[idx] = val;
        writes_sent++;
        drive_word(srlb_pkg::ACT_WRITE, srlb_pkg::IDX_W'(idx), val,
                   srlb_pkg::t_pos'($urandom), srlb_pkg::t_pos'($urandom),
                   srlb_pkg::t_val'($urandom));
    endtask

    task automatic send_query(input int first, input int stop, input srlb_pkg::t_val goal);
        queries_sent++;
        drive_word(srlb_pkg::ACT_QUERY, srlb_pkg::IDX_W'($urandom), srlb_pkg::t_val'($urandom),
                   srlb_pkg::t_pos'(first), srlb_pkg::t_pos'(stop), goal);
    endtask

    task automatic pause_idle(input int gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_all();
        req_ch.valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending != 0);
    endtask

    // ascending run through the array; duplicates allowed
    task automatic cursor_write();
        send_write(cursor, srlb_pkg::t_val'(cursor_val));
        if ($urandom_range(0, 3) != 0)
            cursor_val += longint'($urandom_range(0, 1 << 24));
        if (cursor_val > 64'sd2147483647)
            cursor_val = 64'sd2147483647;
        cursor++;
        if (cursor == srlb_pkg::DEPTH) begin
            cursor = 0;
            cursor_val = -64'sd2147483648 + longint'($urandom_range(0, 1 << 20));
        end
    endtask

    // ranges only cover loaded entries, or are empty after clamping
    task automatic random_query();
        int             first;
        int             stop;
        int             run;
        int             pick;
        srlb_pkg::t_val goal;
        goal = srlb_pkg::t_val'($urandom);
        if ($urandom_range(0, 9) < 2) begin
            first = $urandom_range(srlb_pkg::DEPTH, POS_TOP);
            stop  = $urandom_range(0, POS_TOP);
        end else begin
            first = $urandom_range(0, srlb_pkg::DEPTH - 1);
            repeat (4) if (!loaded[first]) first = $urandom_range(0, srlb_pkg::DEPTH - 1);
            if (!loaded[first]) begin
                stop = $urandom_range(0, first);
            end else begin
                run = first;
                while (run < srlb_pkg::DEPTH && loaded[run]) run++;
                case ($urandom_range(0, 3))
                    0: stop = (run == srlb_pkg::DEPTH && $urandom_range(0, 1) == 1) ?
                              $urandom_range(srlb_pkg::DEPTH, POS_TOP) : run;
                    1: stop = first + $urandom_range(0, (run - first < 8) ? run - first : 8);
                    default: stop = $urandom_range(first, run);
                endcase
                pick = $urandom_range(first, run - 1);
                case ($urandom_range(0, 9))
                    0: goal = VAL_MIN;
                    1: goal = VAL_MAX;
                    2, 3: goal = srlb_pkg::t_val'($urandom);
                    default: goal = shadow[pick] +
                                    srlb_pkg::t_val'(int'($urandom_range(0, 2)) - 1);
                endcase
            end
        end
        send_query(first, stop, goal);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            cursor_write();
        end else if (r < 58) begin
            send_write($urandom_range(0, srlb_pkg::DEPTH - 1), srlb_pkg::t_val'($urandom));
        end else begin
            random_query();
        end
    endtask

    initial begin
        int burst;
        int gap;
        int next_drain;
        for (int i = 0; i < srlb_pkg::DEPTH; i++) loaded[i] = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.action        = srlb_pkg::ACT_WRITE;
        req_ch.element_index = '0;
        req_ch.element_value = '0;
        req_ch.range_start   = '0;
        req_ch.range_end     = '0;
        req_ch.target        = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, duplicates, clamped and empty ranges, one out-of-order entry
        send_write(0, VAL_MIN);
        send_write(1, -7);
        send_write(2, -7);
        send_write(3, 0);
        send_write(4, 100);
        send_write(5, VAL_MAX);
        send_write(1020, 10);
        send_write(1021, 20);
        send_write(1022, 30);
        send_write(1023, 40);
        send_query(0, 6, VAL_MIN);
        send_query(0, 6, VAL_MAX);
        send_query(0, 6, -7);
        send_query(0, 6, 1);
        send_query(1, 5, VAL_MAX);
        send_query(5, 6, VAL_MAX);
        send_query(3, 3, 0);
        send_query(5, 2, 0);
        send_query(1020, POS_TOP, 25);
        send_query(1020, POS_TOP, 41);
        send_query(POS_TOP, POS_TOP, 0);
        send_query(1500, 3, 0);
        send_write(6, -50);
        send_query(0, 7, 50);
        drain_all();

        cursor = 0;
        cursor_val = -64'sd2147483648 + longint'($urandom_range(0, 1 << 20));
        next_drain = DRAIN_EVERY;
        while (writes_sent + queries_sent < ITEM_TOTAL) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                random_item();
                if (writes_sent + queries_sent >= HOLD_AFTER)
                    hold_request = 1'b1;
                if (writes_sent + queries_sent >= next_drain) begin
                    drain_all();
                    next_drain += DRAIN_EVERY;
                end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            pause_idle(gap);
        end

        drain_all();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d element writes and %0d range queries; %0d answers checked, %0d %s",
                 writes_sent, queries_sent, checked, not_found_seen, "with no hit.");
        $display("Long answer-side hold-off of %0d cycles %s.", LONG_HOLD,
                 hold_served ? "taken" : "not reached");
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            if (pending != 0)
                $display("%0d expected answers never arrived", pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sorted_range_lower_bound_search_core.f]
design/srlb_pkg.sv
design/srlb_if.sv
design/srlb_mem.sv
design/srlb_seq.sv
design/sorted_range_lower_bound_search_core.sv
design/srlb_chk.sv
tb/srlb_lower_bound_checker.sv
tb/sorted_range_lower_bound_search_core_test.sv
